### design/mms_pkg.sv
// types, codes and reset constants of the maintenance mode sequencer
package mms_pkg;

	localparam int REG_W       = 19;
	localparam int NUM_REGS    = 6;
	localparam int REG_IDX_W   = 3;
	localparam int TIMER_BITS_DEF = 19;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ARMED_SOFT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ARMED_CAP  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DRAIN      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_JOIN_DL    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_READY_IDLE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ERROR_HOLD = 3'd5;

	// register reset values
	localparam logic [REG_W-1:0] ARMED_SOFT_RST = 19'd3000;
	localparam logic [REG_W-1:0] ARMED_CAP_RST  = 19'd10000;
	localparam logic [REG_W-1:0] DRAIN_RST      = 19'd1000;
	localparam logic [REG_W-1:0] JOIN_DL_RST    = 19'd30000;
	localparam logic [REG_W-1:0] READY_IDLE_RST = 19'd300000;
	localparam logic [REG_W-1:0] ERROR_HOLD_RST = 19'd5000;

	// item kinds
	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_ENTER  = 3'd1;
	localparam logic [2:0] KIND_ABORT  = 3'd2;
	localparam logic [2:0] KIND_UPD_GO = 3'd3;
	localparam logic [2:0] KIND_UPD_ER = 3'd4;

	// mode codes as reported
	localparam logic [2:0] CODE_NORMAL   = 3'd0;
	localparam logic [2:0] CODE_ARMED    = 3'd1;
	localparam logic [2:0] CODE_DRAIN    = 3'd2;
	localparam logic [2:0] CODE_JOINING  = 3'd3;
	localparam logic [2:0] CODE_READY    = 3'd4;
	localparam logic [2:0] CODE_APPLYING = 3'd5;
	localparam logic [2:0] CODE_ERROR    = 3'd6;
	localparam logic [2:0] CODE_ABORTING = 3'd7;

	// display codes
	localparam logic [2:0] SHOW_COUNTDOWN = 3'd0;
	localparam logic [2:0] SHOW_UPLOAD    = 3'd1;
	localparam logic [2:0] SHOW_FAULT     = 3'd2;
	localparam logic [2:0] SHOW_READY     = 3'd3;
	localparam logic [2:0] SHOW_IDLE      = 3'd4;

	typedef enum logic [7:0] {
		MODE_NORMAL   = 8'b0000_0001,
		MODE_ARMED    = 8'b0000_0010,
		MODE_DRAIN    = 8'b0000_0100,
		MODE_JOINING  = 8'b0000_1000,
		MODE_READY    = 8'b0001_0000,
		MODE_APPLYING = 8'b0010_0000,
		MODE_ERROR    = 8'b0100_0000,
		MODE_ABORTING = 8'b1000_0000
	} mode_t;

	// result word, mode in the lowest bits
	typedef struct packed {
		logic [1:0] pad;
		logic [2:0] display_mode;
		logic       display_change;
		logic       start_server;
		logic       start_join;
		logic       stop_radio;
		logic       send_marker;
		logic       reboot;
		logic       active;
		logic       accepted;
		logic [2:0] mode;
	} result_t;

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		unique case (m)
			MODE_NORMAL:   c = CODE_NORMAL;
			MODE_ARMED:    c = CODE_ARMED;
			MODE_DRAIN:    c = CODE_DRAIN;
			MODE_JOINING:  c = CODE_JOINING;
			MODE_READY:    c = CODE_READY;
			MODE_APPLYING: c = CODE_APPLYING;
			MODE_ERROR:    c = CODE_ERROR;
			MODE_ABORTING: c = CODE_ABORTING;
			default:       c = CODE_NORMAL;
		endcase
		return c;
	endfunction

endpackage

### design/maintenance_mode_sequencer.sv
// maintenance mode sequencer top level
//
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | tuser kind, tdata link_ready
//  m_*      | out | m_tvalid/m_tready  | tdata result word
//  cfg_*    | in  | cfg_wen            | cfg_index, cfg_wdata
//
// one word in per cycle while s_tready is high; the result word is registered
// mode and time-in-mode update in the accepting cycle, so words can follow back to back
// s_tready drops only while a result waits and m_tready is low
// arst_n clears mode to normal, the timer to zero and the registers to their defaults
module maintenance_mode_sequencer #(
	parameter int TIMER_BITS = mms_pkg::TIMER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [0] link_ready, [7:1] zero
	input  logic [2:0]                   s_tuser,   // [2:0] kind
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [2:0] mode, [3] accepted, [4] active, [5] reboot, [6] send_marker,
	// [7] stop_radio, [8] start_join, [9] start_server, [10] display_change,
	// [13:11] display_mode, [15:14] zero
	output logic [15:0]                  m_tdata,
	input  logic                         cfg_wen,
	input  logic [mms_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [mms_pkg::REG_W-1:0]    cfg_wdata
);

	localparam int CMP_W = (TIMER_BITS > mms_pkg::REG_W) ? TIMER_BITS : mms_pkg::REG_W;

	logic [mms_pkg::REG_W-1:0] regs_q [mms_pkg::NUM_REGS];
	mms_pkg::mode_t            mode_q, mode_d;
	logic [TIMER_BITS-1:0]     time_q, time_d, t_inc;
	logic [CMP_W-1:0]          t_ext;
	mms_pkg::result_t          res_d, result_q;
	mms_pkg::mode_t            ent_mode;
	logic                      ent;
	logic                      in_acc;
	logic                      link;
	logic [2:0]                kind;

	assign s_tready = !m_tvalid || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign link     = s_tdata[0];
	assign kind     = s_tuser;
	assign m_tdata  = result_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[mms_pkg::REG_ARMED_SOFT] <= mms_pkg::ARMED_SOFT_RST;
			regs_q[mms_pkg::REG_ARMED_CAP]  <= mms_pkg::ARMED_CAP_RST;
			regs_q[mms_pkg::REG_DRAIN]      <= mms_pkg::DRAIN_RST;
			regs_q[mms_pkg::REG_JOIN_DL]    <= mms_pkg::JOIN_DL_RST;
			regs_q[mms_pkg::REG_READY_IDLE] <= mms_pkg::READY_IDLE_RST;
			regs_q[mms_pkg::REG_ERROR_HOLD] <= mms_pkg::ERROR_HOLD_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				mms_pkg::REG_ARMED_SOFT: regs_q[mms_pkg::REG_ARMED_SOFT] <= cfg_wdata;
				mms_pkg::REG_ARMED_CAP:  regs_q[mms_pkg::REG_ARMED_CAP]  <= cfg_wdata;
				mms_pkg::REG_DRAIN:      regs_q[mms_pkg::REG_DRAIN]      <= cfg_wdata;
				mms_pkg::REG_JOIN_DL:    regs_q[mms_pkg::REG_JOIN_DL]    <= cfg_wdata;
				mms_pkg::REG_READY_IDLE: regs_q[mms_pkg::REG_READY_IDLE] <= cfg_wdata;
				mms_pkg::REG_ERROR_HOLD: regs_q[mms_pkg::REG_ERROR_HOLD] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// saturating millisecond count
	assign t_inc = (&time_q) ? time_q : time_q + TIMER_BITS'(1);
	assign t_ext = CMP_W'(t_inc);

	always_comb begin
		mode_d   = mode_q;
		time_d   = time_q;
		res_d    = '0;
		ent      = 1'b0;
		ent_mode = mms_pkg::MODE_NORMAL;
		unique case (kind)
			mms_pkg::KIND_TICK: begin
				time_d = t_inc;
				unique case (mode_q)
					mms_pkg::MODE_ARMED: begin
						// hard cap wins over the soft move to drain
						if (t_ext >= CMP_W'(regs_q[mms_pkg::REG_ARMED_CAP])) begin
							ent      = 1'b1;
							ent_mode = mms_pkg::MODE_ABORTING;
						end else if (t_ext >= CMP_W'(regs_q[mms_pkg::REG_ARMED_SOFT])) begin
							ent      = 1'b1;
							ent_mode = mms_pkg::MODE_DRAIN;
						end
					end
					mms_pkg::MODE_DRAIN: begin
						if (t_ext >= CMP_W'(regs_q[mms_pkg::REG_DRAIN])) begin
							ent      = 1'b1;
							ent_mode = mms_pkg::MODE_JOINING;
						end
					end
					mms_pkg::MODE_JOINING: begin
						if (link) begin
							ent      = 1'b1;
							ent_mode = mms_pkg::MODE_READY;
						end else if (t_ext >= CMP_W'(regs_q[mms_pkg::REG_JOIN_DL])) begin
							mode_d       = mms_pkg::MODE_NORMAL;
							time_d       = '0;
							res_d.reboot = 1'b1;
						end
					end
					mms_pkg::MODE_READY: begin
						if (t_ext >= CMP_W'(regs_q[mms_pkg::REG_READY_IDLE])) begin
							mode_d       = mms_pkg::MODE_NORMAL;
							time_d       = '0;
							res_d.reboot = 1'b1;
						end
					end
					mms_pkg::MODE_ERROR: begin
						if (t_ext >= CMP_W'(regs_q[mms_pkg::REG_ERROR_HOLD])) begin
							mode_d       = mms_pkg::MODE_NORMAL;
							time_d       = '0;
							res_d.reboot = 1'b1;
						end
					end
					mms_pkg::MODE_ABORTING: begin
						mode_d = mms_pkg::MODE_NORMAL;
						time_d = '0;
					end
					default: ;
				endcase
			end
			mms_pkg::KIND_ENTER: begin
				if (mode_q == mms_pkg::MODE_NORMAL) begin
					res_d.accepted = 1'b1;
					ent            = 1'b1;
					ent_mode       = mms_pkg::MODE_ARMED;
				end
			end
			mms_pkg::KIND_ABORT: begin
				if (mode_q == mms_pkg::MODE_ARMED) begin
					ent      = 1'b1;
					ent_mode = mms_pkg::MODE_ABORTING;
				end
			end
			mms_pkg::KIND_UPD_GO: begin
				if (mode_q == mms_pkg::MODE_READY || mode_q == mms_pkg::MODE_APPLYING) begin
					ent      = 1'b1;
					ent_mode = mms_pkg::MODE_APPLYING;
				end
			end
			mms_pkg::KIND_UPD_ER: begin
				if (mode_q == mms_pkg::MODE_READY || mode_q == mms_pkg::MODE_APPLYING) begin
					ent      = 1'b1;
					ent_mode = mms_pkg::MODE_ERROR;
				end
			end
			default: ;
		endcase

		// mode entry: clear timer, raise entry actions
		if (ent) begin
			mode_d = ent_mode;
			time_d = '0;
			unique case (ent_mode)
				mms_pkg::MODE_ARMED: begin
					res_d.send_marker    = 1'b1;
					res_d.display_change = 1'b1;
					res_d.display_mode   = mms_pkg::SHOW_COUNTDOWN;
				end
				mms_pkg::MODE_JOINING: begin
					res_d.stop_radio = 1'b1;
					res_d.start_join = 1'b1;
				end
				mms_pkg::MODE_READY: begin
					res_d.start_server   = 1'b1;
					res_d.display_change = 1'b1;
					res_d.display_mode   = mms_pkg::SHOW_READY;
				end
				mms_pkg::MODE_APPLYING: begin
					res_d.display_change = 1'b1;
					res_d.display_mode   = mms_pkg::SHOW_UPLOAD;
				end
				mms_pkg::MODE_ERROR: begin
					res_d.display_change = 1'b1;
					res_d.display_mode   = mms_pkg::SHOW_FAULT;
				end
				mms_pkg::MODE_ABORTING: begin
					res_d.display_change = 1'b1;
					res_d.display_mode   = mms_pkg::SHOW_IDLE;
				end
				default: ;
			endcase
		end

		res_d.mode   = mms_pkg::mode_code(mode_d);
		res_d.active = (mode_d != mms_pkg::MODE_NORMAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= mms_pkg::MODE_NORMAL;
			time_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (in_acc) begin
				mode_q   <= mode_d;
				time_q   <= time_d;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			result_q <= res_d;
		end
	end

	// state moves only with an accepted word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(mode_q) && $stable(time_q))
		else $error("mode or timer changed without an accepted word");

	// enter in normal is accepted and arms
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && kind == mms_pkg::KIND_ENTER && mode_q == mms_pkg::MODE_NORMAL
		|=> m_tvalid && result_q.accepted && mode_q == mms_pkg::MODE_ARMED)
		else $error("enter request in normal mode not taken");

	// a tick in aborting returns to normal
	a_abort_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && kind == mms_pkg::KIND_TICK && mode_q == mms_pkg::MODE_ABORTING
		|=> mode_q == mms_pkg::MODE_NORMAL && time_q == '0)
		else $error("aborting did not return to normal");

	// a reboot result always leaves the block idle in normal
	a_reboot: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && res_d.reboot
		|=> mode_q == mms_pkg::MODE_NORMAL && time_q == '0
			&& result_q.mode == mms_pkg::CODE_NORMAL)
		else $error("reboot without return to normal");

	// the reported mode follows the state register
	a_mode_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> result_q.mode == mms_pkg::mode_code(mode_q))
		else $error("reported mode differs from state");

endmodule
